/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");

`endif

/* rtl/core/pscg_pkg.sv */
// Types and constants for the packet sequence gap checker.
package pscg_pkg;

    localparam int ID_W    = 16;
    localparam int FIELD_W = 14;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_GAP     = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    process_id;
        logic [FIELD_W-1:0] sequence_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] expected_count;
        logic [FIELD_W-1:0] gap_distance;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_READ  = 3'b100
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;   // write one cleared table entry, advance sweep
        logic take;  // capture input header, launch table read
        logic upd;   // evaluate lookup, write back, load result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;  // sweep is at the last entry
        logic out_free;  // result register can take a new result
    } t_sts;

endpackage

/* rtl/core/pscg_ram.sv */
// Generic simple dual-port RAM with registered read.
module pscg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pscg_ctrl.sv */
// Controller state machine: clearing sweep, header accept, lookup/update.
`include "assert_macros.svh"

module pscg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pscg_pkg::t_sts i_sts,
    output pscg_pkg::t_cmd o_cmd
);

    pscg_pkg::t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pscg_pkg::S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = pscg_pkg::S_IDLE;
                end
            end
            pscg_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pscg_pkg::S_READ;
                end
            end
            pscg_pkg::S_READ: begin
                if (i_sts.out_free) begin
                    n_state = pscg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pscg_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pscg_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands
    always_comb begin
        o_cmd.clr  = (r_state == pscg_pkg::S_CLEAR);
        o_cmd.take = (r_state == pscg_pkg::S_IDLE) && i_in_valid;
        o_cmd.upd  = (r_state == pscg_pkg::S_READ) && i_sts.out_free;
    end

    assign o_in_stall = (r_state != pscg_pkg::S_IDLE);

    `ASSERT_ALWAYS(a_take_to_read, i_clk, i_rst_n, o_cmd.take |=> (r_state == pscg_pkg::S_READ))
    `ASSERT_ALWAYS(a_upd_to_idle, i_clk, i_rst_n, o_cmd.upd |=> (r_state == pscg_pkg::S_IDLE))
    `ASSERT_NEVER(a_clr_with_take, i_clk, i_rst_n, o_cmd.clr && !o_in_stall)

endmodule

/* rtl/core/pscg_dpath.sv */
// Datapath: history table, sequence compare and result register.
`include "assert_macros.svh"

module pscg_dpath #(
    parameter int ID_COUNT   = 2048,
    parameter int COUNT_BITS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pscg_pkg::t_cmd      i_cmd,
    output pscg_pkg::t_sts      o_sts,
    input  pscg_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pscg_pkg::t_out_item o_out_data
);

    localparam int IDX_W   = $clog2(ID_COUNT);
    localparam int STORE_W = (COUNT_BITS < pscg_pkg::FIELD_W) ? COUNT_BITS
                                                              : pscg_pkg::FIELD_W;
    localparam int ENTRY_W = STORE_W + 1;

    logic [pscg_pkg::ID_W-1:0] r_id;
    logic [STORE_W-1:0]        r_cnt;
    logic [IDX_W-1:0]          r_clr_addr;
    logic                      r_out_valid;
    pscg_pkg::t_out_item       r_out, n_out;

    logic                  known;
    logic                  seen;
    logic [COUNT_BITS-1:0] prev, next_cnt, cur, delta;
    logic [ENTRY_W-1:0]    rdata;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]    ram_wdata;

    // Header capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_id  <= i_in_data.process_id;
            r_cnt <= i_in_data.sequence_count[STORE_W-1:0];
        end
    end

    // Clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Table entry: {seen, last count}
    assign ram_raddr = i_cmd.take ? i_in_data.process_id[IDX_W-1:0] : r_id[IDX_W-1:0];
    assign ram_we    = i_cmd.clr || (i_cmd.upd && known);
    assign ram_waddr = i_cmd.clr ? r_clr_addr : r_id[IDX_W-1:0];
    assign ram_wdata = i_cmd.clr ? '0 : {1'b1, r_cnt};

    pscg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ID_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // Sequence compare, modulo 2^COUNT_BITS
    always_comb begin
        known    = ({1'b0, r_id} < (pscg_pkg::ID_W + 1)'(ID_COUNT));
        seen     = rdata[STORE_W];
        prev     = COUNT_BITS'(rdata[STORE_W-1:0]);
        cur      = COUNT_BITS'(r_cnt);
        next_cnt = prev + 1'b1;
        delta    = cur - prev;
        n_out    = '0;
        if (!known) begin
            n_out.status = pscg_pkg::STATUS_UNKNOWN;
        end else if (seen && (cur != next_cnt)) begin
            n_out.status         = pscg_pkg::STATUS_GAP;
            n_out.expected_count = pscg_pkg::FIELD_W'(next_cnt);
            n_out.gap_distance   = pscg_pkg::FIELD_W'(delta);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out <= n_out;
        end
    end

    assign o_sts.clr_done = (r_clr_addr == IDX_W'(ID_COUNT - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    `ASSERT_ALWAYS(a_upd_loads_out, i_clk, i_rst_n, i_cmd.upd |=> r_out_valid)
    `ASSERT_NEVER(a_unknown_write, i_clk, i_rst_n, i_cmd.upd && !known && ram_we)

endmodule

/* rtl/core/packet_sequence_gap_checker.sv */
// Top level of the packet sequence gap checker.
// Each accepted header is looked up in a per-identifier table holding a seen
// flag and the last sequence count; one result transfer follows per header
// (no anomaly, sequence gap with expected count and distance, or unknown
// identifier for ids at or above ID_COUNT). A header goes through the
// registered-read table lookup, then compare, write-back and load of the
// result register, which can hold a finished result while the next header
// is accepted; the load waits while a held result is stalled. After reset a
// clearing pass sweeps the table, one entry per cycle, with o_in_stall high.
module packet_sequence_gap_checker #(
    parameter int ID_COUNT   = 2048,
    parameter int COUNT_BITS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pscg_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pscg_pkg::t_out_item o_out_data
);

    pscg_pkg::t_cmd cmd;
    pscg_pkg::t_sts sts;

    pscg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pscg_dpath #(
        .ID_COUNT   (ID_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
